@@ hw/rtl/plc_pkg.sv @@
package plc_pkg;

  localparam int ID_W    = 32;
  localparam int KIND_W  = 3;
  localparam int LIMIT_W = 7;
  localparam int HELD_W  = 7;
  localparam int ACT_W   = 6;
  localparam int ESC_W   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

  localparam logic [1:0] REQ_BEGIN    = 2'd0;
  localparam logic [1:0] REQ_COMMIT   = 2'd1;
  localparam logic [1:0] REQ_ROLLBACK = 2'd2;
  localparam logic [1:0] REQ_ACQUIRE  = 2'd3;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_NOT_ACTIVE = 2'd1;
  localparam logic [1:0] STS_CONFLICT   = 2'd2;
  localparam logic [1:0] STS_FULL       = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   owner;
    logic [ID_W-1:0]   relation;
    logic [KIND_W-1:0] kind;
  } lock_entry_t;

  typedef struct packed {
    logic set;
    logic clr;
  } txn_cmd_t;

  typedef struct packed {
    logic id_eq;
    logic rel_eq;
    logic conflict;
  } match_t;

endpackage

@@ hw/rtl/plc_match_unit.sv @@
module plc_match_unit (
  input  logic [plc_pkg::ID_W-1:0]   stored_id,
  input  logic [plc_pkg::ID_W-1:0]   stored_rel,
  input  logic [plc_pkg::KIND_W-1:0] stored_kind,
  input  logic [plc_pkg::ID_W-1:0]   req_id,
  input  logic [plc_pkg::ID_W-1:0]   req_rel,
  input  logic [plc_pkg::KIND_W-1:0] req_kind,
  output plc_pkg::match_t            result
);
  import plc_pkg::*;

  // low bit of the kind marks a write lock
  always_comb begin
    result.id_eq    = (stored_id == req_id);
    result.rel_eq   = (stored_rel == req_rel);
    result.conflict = !result.id_eq && result.rel_eq && (stored_kind[0] || req_kind[0]);
  end

endmodule

@@ hw/rtl/plc_txn_store.sv @@
module plc_txn_store #(
  parameter int SLOTS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [$clog2(SLOTS)-1:0]  rd_idx,
  output logic [plc_pkg::ID_W-1:0]  rd_id,
  input  plc_pkg::txn_cmd_t         cmd,
  input  logic [$clog2(SLOTS)-1:0]  wr_idx,
  input  logic [plc_pkg::ID_W-1:0]  wr_id,
  output logic [SLOTS-1:0]          valid_vec
);
  import plc_pkg::*;

  logic [ID_W-1:0]  id_mem [SLOTS];
  logic [SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      id_mem[wr_idx] <= wr_id;
    end
    rd_id <= id_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.set) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (cmd.clr) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  assign valid_vec = valid_r;

endmodule

@@ hw/rtl/plc_lock_ring.sv @@
module plc_lock_ring #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  plc_pkg::lock_entry_t      wr_data,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output plc_pkg::lock_entry_t      rd_data
);
  import plc_pkg::*;

  lock_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/predicate_lock_conflict_table.sv @@
// Request engine for a set of active transactions and a ring of predicate locks. An item is
// transferred when start is high and busy is low; busy then stays high until the result has been
// issued. Every request first scans all TXN_SLOTS transaction slots through one compare unit,
// one slot per cycle from a registered memory read; an acquire by an active transaction then
// scans the stored locks the same way, one per cycle, and appends. Begin, commit, rollback and
// an acquire by an inactive transaction finish after the slot scan and the decide step; a granted
// acquire also passes through the lock scan, the drop step and the append, and a conflict ends
// the lock scan early and skips the append. The result appears on the out_ ports for exactly
// one cycle with out_valid high and cannot be stalled, so the receiver must take it in that
// cycle. lock_limit may only be written while busy is low.
module predicate_lock_conflict_table #(
  parameter int LOCK_DEPTH = 64,
  parameter int TXN_SLOTS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_req_type,
  input  logic [plc_pkg::ID_W-1:0]     in_txn_id,
  input  logic [plc_pkg::KIND_W-1:0]   in_lock_kind,
  input  logic [plc_pkg::ID_W-1:0]     in_relation_id,
  input  logic                         cfg_wr_en,
  input  logic [plc_pkg::LIMIT_W-1:0]  cfg_wr_data,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [1:0]                   out_status,
  output logic [plc_pkg::HELD_W-1:0]   out_locks_held,
  output logic [plc_pkg::ESC_W-1:0]    out_escalations,
  output logic [plc_pkg::ACT_W-1:0]    out_active_txns
);
  import plc_pkg::*;

  localparam int TAW = $clog2(TXN_SLOTS);
  localparam int TCW = $clog2(TXN_SLOTS + 1);
  localparam int LAW = $clog2(LOCK_DEPTH);
  localparam int FW  = $clog2(LOCK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TSCAN  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_LSCAN  = 3'd3;
  localparam logic [2:0] S_DROP   = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]         state_r;
  logic [1:0]         req_r;
  logic [ID_W-1:0]    id_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ID_W-1:0]    rel_r;
  logic [1:0]         status_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [TCW-1:0]     issue_r;
  logic               tpv_r;
  logic [TAW-1:0]     tidx_r;
  logic               found_r;
  logic [TAW-1:0]     slot_r;
  logic               free_ok_r;
  logic [TAW-1:0]     free_r;
  logic [TCW-1:0]     act_r;

  logic [LAW-1:0]     oldest_r;
  logic [FW-1:0]      fill_r;
  logic [LAW-1:0]     lptr_r;
  logic [FW-1:0]      lcnt_r;
  logic               lpv_r;
  logic               conflict_r;
  logic [ESC_W-1:0]   esc_r;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [1:0]         out_status_r;
  logic [HELD_W-1:0]  out_held_r;
  logic [ESC_W-1:0]   out_esc_r;
  logic [ACT_W-1:0]   out_act_r;

  logic               accept;
  logic [ID_W-1:0]    txn_rd_id;
  logic [TXN_SLOTS-1:0] txn_valid;
  txn_cmd_t           txn_cmd;
  logic [TAW-1:0]     txn_wr_idx;
  lock_entry_t        lock_rd;
  lock_entry_t        lock_wr;
  logic               lock_we;
  logic [LAW-1:0]     lock_wr_addr;
  match_t             cmp;
  logic [ID_W-1:0]    cmp_id;
  logic               t_issue;
  logic               l_issue;
  logic [FW-1:0]      lim_eff;
  logic [FW:0]        fill_inc;
  logic [FW:0]        drop;
  logic [FW:0]        old_sum;
  logic [LAW-1:0]     old_wrap;
  logic [FW:0]        app_sum;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  plc_txn_store #(.SLOTS(TXN_SLOTS)) u_txn (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (issue_r[TAW-1:0]),
    .rd_id     (txn_rd_id),
    .cmd       (txn_cmd),
    .wr_idx    (txn_wr_idx),
    .wr_id     (id_r),
    .valid_vec (txn_valid)
  );

  plc_lock_ring #(.DEPTH(LOCK_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (lock_we),
    .wr_addr (lock_wr_addr),
    .wr_data (lock_wr),
    .rd_addr (lptr_r),
    .rd_data (lock_rd)
  );

  // one compare unit shared by the slot scan and the lock scan
  assign cmp_id = (state_r == S_LSCAN) ? lock_rd.owner : txn_rd_id;

  plc_match_unit u_cmp (
    .stored_id   (cmp_id),
    .stored_rel  (lock_rd.relation),
    .stored_kind (lock_rd.kind),
    .req_id      (id_r),
    .req_rel     (rel_r),
    .req_kind    (kind_r),
    .result      (cmp)
  );

  assign t_issue = (issue_r != TCW'(TXN_SLOTS));
  assign l_issue = (lcnt_r != fill_r) && !conflict_r;

  always_comb begin
    if (limit_r == '0) begin
      lim_eff = FW'(1);
    end else if (32'(limit_r) > 32'(LOCK_DEPTH)) begin
      lim_eff = FW'(LOCK_DEPTH);
    end else begin
      lim_eff = FW'(limit_r);
    end
    fill_inc = (FW+1)'(fill_r) + (FW+1)'(1);
    drop     = fill_inc - (FW+1)'(lim_eff);
    old_sum  = (FW+1)'(oldest_r) + drop;
    if (old_sum >= (FW+1)'(LOCK_DEPTH)) begin
      old_wrap = LAW'(old_sum - (FW+1)'(LOCK_DEPTH));
    end else begin
      old_wrap = LAW'(old_sum);
    end
    app_sum = (FW+1)'(oldest_r) + (FW+1)'(fill_r);
    if (app_sum >= (FW+1)'(LOCK_DEPTH)) begin
      lock_wr_addr = LAW'(app_sum - (FW+1)'(LOCK_DEPTH));
    end else begin
      lock_wr_addr = LAW'(app_sum);
    end
  end

  always_comb begin
    txn_cmd    = '0;
    txn_wr_idx = slot_r;
    if (state_r == S_DECIDE) begin
      case (req_r)
        REQ_BEGIN: begin
          if (!found_r && free_ok_r) begin
            txn_cmd.set = 1'b1;
            txn_wr_idx  = free_r;
          end
        end
        REQ_COMMIT, REQ_ROLLBACK: begin
          txn_cmd.clr = found_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign lock_we       = (state_r == S_APPEND);
  assign lock_wr.owner    = id_r;
  assign lock_wr.relation = rel_r;
  assign lock_wr.kind     = kind_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      id_r   <= in_txn_id;
      kind_r <= in_lock_kind;
      rel_r  <= in_relation_id;
    end
    if (state_r == S_TSCAN && tpv_r) begin
      if (txn_valid[tidx_r] && cmp.id_eq && !found_r) begin
        slot_r <= tidx_r;
      end
      if (!txn_valid[tidx_r] && !free_ok_r) begin
        free_r <= tidx_r;
      end
    end
    if (state_r == S_DONE) begin
      out_ok_r     <= (status_r == STS_OK);
      out_status_r <= status_r;
      out_held_r   <= HELD_W'(fill_r);
      out_esc_r    <= esc_r;
      out_act_r    <= ACT_W'(act_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= STS_OK;
      limit_r     <= LIMIT_RST;
      issue_r     <= '0;
      tpv_r       <= 1'b0;
      tidx_r      <= '0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      act_r       <= '0;
      oldest_r    <= '0;
      fill_r      <= '0;
      lptr_r      <= '0;
      lcnt_r      <= '0;
      lpv_r       <= 1'b0;
      conflict_r  <= 1'b0;
      esc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            status_r  <= STS_OK;
            issue_r   <= '0;
            tpv_r     <= 1'b0;
            found_r   <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= S_TSCAN;
          end
        end
        S_TSCAN: begin
          tpv_r  <= t_issue;
          tidx_r <= issue_r[TAW-1:0];
          if (t_issue) begin
            issue_r <= issue_r + TCW'(1);
          end
          if (tpv_r) begin
            if (txn_valid[tidx_r] && cmp.id_eq) begin
              found_r <= 1'b1;
            end
            if (!txn_valid[tidx_r]) begin
              free_ok_r <= 1'b1;
            end
            if (tidx_r == TAW'(TXN_SLOTS - 1)) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          state_r <= (req_r == REQ_ACQUIRE && found_r) ? S_LSCAN : S_DONE;
          unique case (req_r)
            REQ_BEGIN: begin
              if (!found_r) begin
                if (free_ok_r) begin
                  act_r <= act_r + TCW'(1);
                end else begin
                  status_r <= STS_FULL;
                end
              end
            end
            REQ_COMMIT, REQ_ROLLBACK: begin
              if (found_r) begin
                act_r <= act_r - TCW'(1);
              end else if (req_r == REQ_COMMIT) begin
                status_r <= STS_NOT_ACTIVE;
              end
            end
            REQ_ACQUIRE: begin
              if (!found_r) begin
                status_r <= STS_NOT_ACTIVE;
              end else begin
                lptr_r     <= oldest_r;
                lcnt_r     <= '0;
                lpv_r      <= 1'b0;
                conflict_r <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_LSCAN: begin
          lpv_r <= l_issue;
          if (l_issue) begin
            lcnt_r <= lcnt_r + FW'(1);
            if (lptr_r == LAW'(LOCK_DEPTH - 1)) begin
              lptr_r <= '0;
            end else begin
              lptr_r <= lptr_r + LAW'(1);
            end
          end
          if (lpv_r && cmp.conflict) begin
            conflict_r <= 1'b1;
          end
          if (!l_issue && !lpv_r) begin
            if (conflict_r) begin
              status_r <= STS_CONFLICT;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_DROP;
            end
          end
        end
        S_DROP: begin
          // drop oldest locks so the append stays within the limit, one escalation
          if (fill_inc > (FW+1)'(lim_eff)) begin
            oldest_r <= old_wrap;
            fill_r   <= lim_eff - FW'(1);
            if (esc_r != '1) begin
              esc_r <= esc_r + ESC_W'(1);
            end
          end
          state_r <= S_APPEND;
        end
        S_APPEND: begin
          fill_r  <= fill_r + FW'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_status      = out_status_r;
  assign out_locks_held  = out_held_r;
  assign out_escalations = out_esc_r;
  assign out_active_txns = out_act_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("no busy after transfer");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside end of request");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(LOCK_DEPTH))
    else $error("lock fill beyond ring depth");

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(act_r) == 32'($countones(txn_valid)))
    else $error("active count out of step with slot valid bits");

endmodule
